// ===== rtl/sacr_pkg.sv =====
// ---------------------------------------------------------------------------
// sacr_pkg
// Shared types and constants for the set-associative cache tag model with
// random replacement.
// ---------------------------------------------------------------------------
package sacr_pkg;

   localparam int CNT_W      = 48;
   localparam int SEED_W     = 16;
   localparam int RSP_W      = 104;   // 99 field bits padded to whole bytes
   localparam logic [SEED_W-1:0] LFSR_RESET = 16'd44257;
   localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic clear_row;   // zero one row of valid bits
      logic read_row;    // latch address, read the set
      logic commit;      // resolve lookup, update state, load result word
   } cmd_type;

   typedef struct packed {
      logic clear_last;  // clearing sweep is on its last row
   } status_type;

endpackage

// ===== rtl/set_assoc_cache_random_repl.sv =====
// ---------------------------------------------------------------------------
// set_assoc_cache_random_repl
// Set-associative cache tag model with LFSR-driven random replacement.
//
// req channel : one byte address per word. The block splits it into line
//               offset, set index and tag, and looks the tag up in its set.
// rsp channel : one word per request: hit flag, way hit or filled, eviction
//               flag and the saturating hit and miss totals after the access.
// csr channel : a write loads the 16-bit seed straight into the LFSR.
// Each request is handled in two steps: a read of the set's row from the tag and
// valid memories, then a compare, a choice of way and a write-back of the row.
// The row memories are read in the idle state and written in the lookup state;
// the result word is registered, and a new request is taken only once the last
// one has been committed.
// After reset the valid bits are swept clear, one set per cycle, before req_tready
// rises. The LFSR reloads 44257 and both counters clear. If rsp stalls, the
// finished word is held in its register; one more request is taken and waits
// there for the register.
// ---------------------------------------------------------------------------
module set_assoc_cache_random_repl #(
   parameter int NUM_SET_COUNT = 64,
   parameter int WAY_COUNT     = 2,
   parameter int LINE_BYTES    = 64,
   parameter int ADDR_WIDTH    = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // address (ADDR_WIDTH bits), zero padded to bytes
   input  logic [((ADDR_WIDTH+7)/8)*8-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // hit, way, evicted, hit_total[47:0], miss_total[47:0], 5 zero bits
   output logic [sacr_pkg::RSP_W-1:0]          rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sacr_pkg::SEED_W-1:0]         csr_data
);
   import sacr_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   sacr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sacr_dp #(
      .NUM_SET_COUNT (NUM_SET_COUNT),
      .WAY_COUNT     (WAY_COUNT),
      .LINE_BYTES    (LINE_BYTES),
      .ADDR_WIDTH    (ADDR_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .address   (req_tdata[ADDR_WIDTH-1:0]),
      .csr_write (csr_valid & csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== rtl/sacr_ctrl.sv =====
// ---------------------------------------------------------------------------
// sacr_ctrl
// Controller: runs the valid-bit clearing sweep after reset, sequences each
// lookup and holds the result word's valid flag.
// ---------------------------------------------------------------------------
module sacr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  sacr_pkg::status_type status,
   output sacr_pkg::cmd_type    cmd
);
   import sacr_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_row = 1'b1;
         end
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.read_row = req_tvalid;
         end
         ST_LOOKUP: begin
            cmd.commit = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit)      rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/sacr_dp.sv =====
// ---------------------------------------------------------------------------
// sacr_dp
// Datapath: tag and valid memories, way compare, victim choice, replacement
// LFSR, saturating counters and the result word register.
// ---------------------------------------------------------------------------
module sacr_dp #(
   parameter int NUM_SET_COUNT = 64,
   parameter int WAY_COUNT     = 2,
   parameter int LINE_BYTES    = 64,
   parameter int ADDR_WIDTH    = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ADDR_WIDTH-1:0]         address,
   input  logic                          csr_write,
   input  logic [sacr_pkg::SEED_W-1:0]   csr_data,
   input  sacr_pkg::cmd_type             cmd,
   output sacr_pkg::status_type          status,
   output logic [sacr_pkg::RSP_W-1:0]    rsp_tdata
);
   import sacr_pkg::*;

   localparam int OFF_W     = $clog2(LINE_BYTES);
   localparam int SET_BITS  = $clog2(NUM_SET_COUNT);
   localparam int SET_W     = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int TAG_BITS  = ADDR_WIDTH - OFF_W - SET_BITS;
   localparam int TAG_W     = (TAG_BITS > 0) ? TAG_BITS : 1;
   localparam int WAY_IDX_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
   localparam int ROW_W     = WAY_COUNT * TAG_W;

   logic [WAY_COUNT-1:0] vld_mem [NUM_SET_COUNT];
   logic [ROW_W-1:0]     tag_mem [NUM_SET_COUNT];

   logic [ADDR_WIDTH-1:0] blk;
   logic [SET_W-1:0]      set_now;
   logic [TAG_W-1:0]      tag_now;

   logic [SET_W-1:0]      set_ff;
   logic [TAG_W-1:0]      tag_ff;
   logic [WAY_COUNT-1:0]  vld_rd_ff;
   logic [ROW_W-1:0]      tag_rd_ff;
   logic [SET_W-1:0]      clr_ff, clr_in;
   logic [SEED_W-1:0]     lfsr_ff, lfsr_in;
   logic [CNT_W-1:0]      hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0]      miss_cnt_ff, miss_cnt_in;
   logic [RSP_W-1:0]      rsp_ff;

   logic [WAY_COUNT-1:0]  hit_vec;
   logic                  hit_any, inv_any, evict;
   logic [WAY_IDX_W-1:0]  hit_idx, inv_idx, pick;
   logic [WAY_COUNT-1:0]  vld_new;
   logic [ROW_W-1:0]      tag_row_new;
   logic                  lfsr_fb;

   assign blk     = address >> OFF_W;
   assign set_now = SET_W'(blk & ADDR_WIDTH'(NUM_SET_COUNT - 1));
   assign tag_now = TAG_W'(blk >> SET_BITS);

   // way compare, lowest hit and lowest invalid way
   always_comb begin
      hit_any = 1'b0;
      inv_any = 1'b0;
      hit_idx = '0;
      inv_idx = '0;
      for (int w = WAY_COUNT - 1; w >= 0; w--) begin
         hit_vec[w] = vld_rd_ff[w] && (tag_rd_ff[w*TAG_W +: TAG_W] == tag_ff);
         if (hit_vec[w]) begin
            hit_any = 1'b1;
            hit_idx = WAY_IDX_W'(w);
         end
         if (!vld_rd_ff[w]) begin
            inv_any = 1'b1;
            inv_idx = WAY_IDX_W'(w);
         end
      end
   end

   assign evict = !hit_any && !inv_any;

   always_comb begin
      priority if (hit_any) pick = hit_idx;
      else if (inv_any)     pick = inv_idx;
      else                  pick = lfsr_ff[WAY_IDX_W-1:0] & WAY_IDX_W'(WAY_COUNT - 1);
   end

   always_comb begin
      vld_new     = vld_rd_ff;
      tag_row_new = tag_rd_ff;
      for (int w = 0; w < WAY_COUNT; w++) begin
         if (pick == WAY_IDX_W'(w)) begin
            vld_new[w]                   = 1'b1;
            tag_row_new[w*TAG_W +: TAG_W] = tag_ff;
         end
      end
   end

   // Fibonacci LFSR, taps 16,14,13,11
   assign lfsr_fb = lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5];

   always_comb begin
      priority if (csr_write)      lfsr_in = csr_data;
      else if (cmd.commit && evict) lfsr_in = {lfsr_fb, lfsr_ff[SEED_W-1:1]};
      else                         lfsr_in = lfsr_ff;
   end

   always_comb begin
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      if (cmd.commit) begin
         if (hit_any) begin
            if (hit_cnt_ff != CNT_MAX) hit_cnt_in = hit_cnt_ff + CNT_W'(1);
         end else begin
            if (miss_cnt_ff != CNT_MAX) miss_cnt_in = miss_cnt_ff + CNT_W'(1);
         end
      end
   end

   assign clr_in            = cmd.clear_row ? clr_ff + SET_W'(1) : clr_ff;
   assign status.clear_last = (clr_ff == SET_W'(NUM_SET_COUNT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         lfsr_ff     <= LFSR_RESET;
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         lfsr_ff     <= lfsr_in;
         hit_cnt_ff  <= hit_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_row) begin
         set_ff    <= set_now;
         tag_ff    <= tag_now;
         vld_rd_ff <= vld_mem[set_now];
         tag_rd_ff <= tag_mem[set_now];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_row) begin
         vld_mem[clr_ff] <= '0;
      end else if (cmd.commit && !hit_any) begin
         vld_mem[set_ff] <= vld_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && !hit_any) begin
         tag_mem[set_ff] <= tag_row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= {5'd0, miss_cnt_in, hit_cnt_in, evict, pick[0], hit_any};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule
